// ----- design/amvd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the accelerometer motion variance detector.
// No dependencies.
package amvd_pkg;

  localparam int unsigned AX_W      = 12;   // one axis sample
  localparam int unsigned MAG_W     = 13;   // |x|+|y|+|z|, up to 6144
  localparam int unsigned DIV_W     = 32;   // dividend width of the shared divider
  localparam int unsigned SCALE_W   = 7;
  localparam int unsigned VAR_W     = 16;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [SCALE_W-1:0] SCALE_FACTOR = 7'd100;
  localparam logic [VAR_W-1:0]   VAR_SAT      = 16'hFFFF;

  // magnitude of a two's complement axis sample; -2048 maps to 2048
  function automatic logic [AX_W-1:0] abs_axis(input logic [AX_W-1:0] v);
    abs_axis = v[AX_W-1] ? (~v + AX_W'(1)) : v;
  endfunction

endpackage

// ----- design/amvd_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on amvd_pkg for the dividend width.
module amvd_div import amvd_pkg::*; #(
  parameter int unsigned DVS_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    rem_shift;
  logic [DVS_W:0]    rem_sub;

  assign rem_shift = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/accel_motion_variance_detect_top.sv -----
`timescale 1ns / 1ps
// Top level of the accelerometer motion variance detector.
// Depends on amvd_pkg and amvd_div.

// Samples load at one transaction per cycle; each magnitude, while there is
// room, goes into a single-port-write, registered-read store of MAX_SAMPLES
// entries. A transaction with tlast closes the window and s_axis_tready
// drops while the result is worked out: the shared bit-serial divider
// forms the mean, the N stored magnitudes are streamed through the
// deviation-square-accumulate pipeline, the sum is scaled by x100, the
// divider runs again and the output register is loaded. The output
// register lets the next window load while the last result waits. No
// clearing pass after reset.
module accel_motion_variance_detect_top import amvd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,   // move_threshold
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [11:0] accel_x, [23:12] accel_y, [35:24] accel_z, [39:36] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,  // last_sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] variance_value, [16] is_still, [17] window_overflow, [23:18] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = MAG_W + ADDR_W;
  localparam int unsigned SQ_W   = 2 * MAG_W;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_MEAN   = 3'd1;
  localparam logic [2:0] ST_PASS   = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_VSTART = 3'd4;
  localparam logic [2:0] ST_VAR    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d;
  logic [31:0]      thr_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             p1_q, p2_q, p3_q;

  logic [MAG_W-1:0] mean_q;
  logic [MAG_W-1:0] rdata_q;
  logic [MAG_W-1:0] dev_q;
  logic [SQ_W-1:0]  sq_q;
  logic [31:0]      acc_q;
  logic [DIV_W-1:0] scaled_q;
  logic [DIV_W-1:0] var_q;

  logic             out_valid_q;
  logic [VAR_W-1:0] out_value_q;
  logic             out_still_q;
  logic             out_ovf_q;

  logic [MAG_W-1:0] mem [MAX_SAMPLES];

  logic                    in_hs;
  logic                    room;
  logic                    mem_we;
  logic                    rd_en;
  logic                    out_load;
  logic [MAG_W-1:0]        mag;
  logic [DIV_W+SCALE_W-1:0] scaled_full;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [DIV_W-1:0]        div_quo;
  logic                    div_done;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign room          = (count_q < CNT_W'(MAX_SAMPLES));
  assign mem_we        = in_hs && room;
  assign rd_en         = (state_q == ST_PASS) && (idx_q < count_q);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign mag = MAG_W'(abs_axis(s_axis_tdata[AX_W-1:0]))
             + MAG_W'(abs_axis(s_axis_tdata[2*AX_W-1:AX_W]))
             + MAG_W'(abs_axis(s_axis_tdata[3*AX_W-1:2*AX_W]));

  assign scaled_full = {{SCALE_W{1'b0}}, acc_q} * {{DIV_W{1'b0}}, SCALE_FACTOR};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sum_d        = sum_q;
    ovf_d        = ovf_q;
    idx_d        = idx_q;
    div_start    = 1'b0;
    div_dividend = scaled_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_hs) begin
          if (room) begin
            count_d = count_q + CNT_W'(1);
            sum_d   = sum_q + SUM_W'(mag);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sum_d);
            state_d      = ST_MEAN;
          end
        end
      end
      ST_MEAN: begin
        idx_d = '0;
        if (div_done) begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        if (rd_en) begin
          idx_d = idx_q + CNT_W'(1);
        end else if (!p1_q && !p2_q && !p3_q) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_VSTART;
      end
      ST_VSTART: begin
        div_start = 1'b1;
        state_d   = ST_VAR;
      end
      ST_VAR: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          count_d = '0;
          sum_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      thr_q       <= '0;
      idx_q       <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      p3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      p1_q    <= rd_en;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // magnitude store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[ADDR_W-1:0]] <= mag;
    end
    if (rd_en) begin
      rdata_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  // mean capture, deviation, square, accumulate (wraps at 32 bits), scaling and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEAN && div_done) begin
      mean_q <= div_quo[MAG_W-1:0];
      acc_q  <= '0;
    end
    if (p1_q) begin
      dev_q <= (rdata_q >= mean_q) ? (rdata_q - mean_q) : (mean_q - rdata_q);
    end
    if (p2_q) begin
      sq_q <= dev_q * dev_q;
    end
    if (p3_q) begin
      acc_q <= acc_q + 32'(sq_q);
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= scaled_full[DIV_W-1:0];
    end
    if (state_q == ST_VAR && div_done) begin
      var_q <= div_quo;
    end
    if (out_load) begin
      out_value_q <= (var_q[DIV_W-1:VAR_W] != '0) ? VAR_SAT : var_q[VAR_W-1:0];
      out_still_q <= (var_q < thr_q);
      out_ovf_q   <= ovf_q;
    end
  end

  amvd_div #(
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - VAR_W - 2){1'b0}}, out_ovf_q, out_still_q, out_value_q};

endmodule

// ----- design/amvd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the motion variance detector, bound to its top level.
// Depends on amvd_pkg for the stream widths.
module amvd_checker import amvd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // window end stops intake for the computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken during variance computation");

  // a new result only comes out of a computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a closed window");

endmodule

bind accel_motion_variance_detect_top amvd_checker u_amvd_checker (.*);
